// ===== hdl/frac_pkg.sv =====
// ----------------------------------------------------------------------------
// frac_pkg: shared types and constants for fraction_arith_reduce
// Operation codes, widths and the sequencer state type.
// ----------------------------------------------------------------------------
package frac_pkg;

   localparam int OPERAND_WIDTH_DEF = 16;
   localparam int NUM_OUT_W         = 33;
   localparam int DEN_OUT_W         = 32;

   typedef enum logic [1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SUM,
      ST_GCD,
      ST_DIVN,
      ST_DIVD,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/fraction_arith_reduce.sv =====
// ----------------------------------------------------------------------------
// fraction_arith_reduce: exact fraction arithmetic reduced to lowest terms
//
// Usage:
//   Drive req_command and the four signed operands, pulse start while busy
//   is low; the item is taken on that edge and busy rises next cycle.
//   The block forms the cross products (one shared multiplier, one product a
//   cycle), combines them in sign-magnitude, then runs Euclid's GCD with a
//   shared bit-serial divider (one remainder per step) and divides numerator
//   and denominator by the GCD with the same divider.
//   Sequence: with W = 2*OW+2 (34 at the default width) and k Euclid steps,
//   busy stays high through the three products, the combine, k divides of
//   W bits for Euclid, then the divides of numerator and denominator and
//   the done state; the result strobe follows in the next cycle.
//   k is at most about 46 for these magnitudes. A zero denominator sets
//   rsp_divide_error with 0/1; zero numerator gives 0/1 without division.
//   Throughput: a new item can be taken at the edge that ends the strobe.
//   The result shows for one cycle with rsp_valid; the receiver cannot
//   stall. Reset (synchronous, high) returns the sequencer to idle; no item
//   in flight survives.
// ----------------------------------------------------------------------------
module fraction_arith_reduce #(
   parameter int OPERAND_WIDTH = frac_pkg::OPERAND_WIDTH_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_command,
   input  logic signed [OPERAND_WIDTH-1:0]        req_a_num,
   input  logic signed [OPERAND_WIDTH-1:0]        req_a_den,
   input  logic signed [OPERAND_WIDTH-1:0]        req_b_num,
   input  logic signed [OPERAND_WIDTH-1:0]        req_b_den,
   output logic                                   rsp_valid,
   output logic signed [frac_pkg::NUM_OUT_W-1:0]  rsp_result_num,
   output logic signed [frac_pkg::DEN_OUT_W-1:0]  rsp_result_den,
   output logic                                   rsp_divide_error
);
   localparam int OW = OPERAND_WIDTH;
   localparam int PW = 2 * OW;      // product magnitude width
   localparam int W  = PW + 2;      // sum magnitude width, with margin

   frac_pkg::state_type st_ff, st_in;

   // operand magnitudes and signs
   logic [OW:0]   mag_an_ff, mag_ad_ff, mag_bn_ff, mag_bd_ff;
   logic          sg_an_ff, sg_ad_ff, sg_bn_ff, sg_bd_ff;
   logic [1:0]    cmd_ff;
   logic [1:0]    step_ff, step_in;

   // products, sign-magnitude
   logic [PW+1:0] p0_ff, p0_in, p1_ff, p1_in, p2_ff, p2_in;
   logic          s0_ff, s0_in, s1_ff, s1_in, s2_ff, s2_in;

   // numerator / denominator and GCD registers
   logic [W-1:0]  num_ff, num_in, den_ff, den_in, gx_ff, gx_in, gy_ff, gy_in;
   logic          nneg_ff, nneg_in, dneg_ff, dneg_in;
   logic          err_ff, err_in, vld_ff, vld_in;

   // shared multiplier
   logic [OW:0]   mx, my;
   logic [PW+1:0] mp;
   logic          msg;

   // shared divider
   logic          dgo;
   logic [W-1:0]  ddvd, ddvs, dq, dr;
   logic          ddone, dwait_ff, dwait_in;

   logic [W-1:0]  sum_mag;
   logic          sum_neg;

   frac_divu #(.W(W)) u_div (
      .clock, .reset, .go(dgo), .dividend(ddvd), .divisor(ddvs),
      .done(ddone), .quot(dq), .rem(dr)
   );

   function automatic logic [OW:0] mag_of(input logic [OW-1:0] v);
      mag_of = v[OW-1] ? ((OW+1)'(0) - {v[OW-1], v}) : {1'b0, v};
   endfunction

   // capture operands in sign-magnitude form
   always_ff @(posedge clock) begin
      if (st_ff == frac_pkg::ST_IDLE && start) begin
         cmd_ff    <= req_command;
         mag_an_ff <= mag_of(req_a_num);  sg_an_ff <= req_a_num[OW-1];
         mag_ad_ff <= mag_of(req_a_den);  sg_ad_ff <= req_a_den[OW-1];
         mag_bn_ff <= mag_of(req_b_num);  sg_bn_ff <= req_b_num[OW-1];
         mag_bd_ff <= mag_of(req_b_den);  sg_bd_ff <= req_b_den[OW-1];
      end
   end

   // multiplier operand select per step: 0 an*bd (or an*bn), 1 ad*bn, 2 den
   always_comb begin
      mx  = mag_an_ff;  my = mag_bd_ff;
      msg = sg_an_ff ^ sg_bd_ff;
      case (step_ff)
         2'd0: begin
            mx = mag_an_ff; my = mag_bd_ff; msg = sg_an_ff ^ sg_bd_ff;
            if (cmd_ff == frac_pkg::CMD_MUL) begin
               my = mag_bn_ff; msg = sg_an_ff ^ sg_bn_ff;
            end
         end
         2'd1: begin
            mx = mag_ad_ff; my = mag_bn_ff; msg = sg_ad_ff ^ sg_bn_ff;
         end
         2'd2: begin
            mx = mag_ad_ff; my = mag_bd_ff; msg = sg_ad_ff ^ sg_bd_ff;
            if (cmd_ff == frac_pkg::CMD_DIV) begin
               my = mag_bn_ff; msg = sg_ad_ff ^ sg_bn_ff;
            end
         end
         default: begin
            mx = '0; my = '0; msg = 1'b0;
         end
      endcase
   end
   assign mp = mx * my;

   // signed combine of the two cross products
   always_comb begin
      logic s1e;
      s1e = s1_ff ^ (cmd_ff == frac_pkg::CMD_SUB);
      if (s0_ff == s1e) begin
         sum_mag = W'(p0_ff) + W'(p1_ff);
         sum_neg = s0_ff;
      end else if (p0_ff >= p1_ff) begin
         sum_mag = W'(p0_ff - p1_ff);
         sum_neg = s0_ff;
      end else begin
         sum_mag = W'(p1_ff - p0_ff);
         sum_neg = s1e;
      end
   end

   always_comb begin
      st_in    = st_ff;
      step_in  = step_ff;
      p0_in = p0_ff; p1_in = p1_ff; p2_in = p2_ff;
      s0_in = s0_ff; s1_in = s1_ff; s2_in = s2_ff;
      num_in = num_ff; den_in = den_ff; gx_in = gx_ff; gy_in = gy_ff;
      nneg_in = nneg_ff; dneg_in = dneg_ff;
      err_in   = err_ff;
      vld_in   = 1'b0;
      dgo      = 1'b0;
      ddvd     = gx_ff;
      ddvs     = gy_ff;
      dwait_in = dwait_ff;
      case (st_ff)
         frac_pkg::ST_IDLE: begin
            if (start) begin
               st_in   = frac_pkg::ST_MUL;
               step_in = 2'd0;
            end
         end
         frac_pkg::ST_MUL: begin
            case (step_ff)
               2'd0: begin p0_in = mp; s0_in = msg; end
               2'd1: begin p1_in = mp; s1_in = msg; end
               default: begin p2_in = mp; s2_in = msg; end
            endcase
            if (step_ff == 2'd2) st_in = frac_pkg::ST_SUM;
            else step_in = step_ff + 2'd1;
         end
         frac_pkg::ST_SUM: begin
            if (cmd_ff == frac_pkg::CMD_ADD || cmd_ff == frac_pkg::CMD_SUB) begin
               num_in  = sum_mag;
               nneg_in = sum_neg;
            end else begin
               num_in  = W'(p0_ff);
               nneg_in = s0_ff;
            end
            den_in  = W'(p2_ff);
            dneg_in = s2_ff;
            gx_in   = num_in;
            gy_in   = den_in;
            err_in  = 1'b0;
            dwait_in = 1'b0;
            if (p2_ff == '0) begin
               err_in = 1'b1;
               num_in = '0; den_in = W'(1); nneg_in = 1'b0; dneg_in = 1'b0;
               st_in  = frac_pkg::ST_DONE;
            end else if (num_in == '0) begin
               den_in = W'(1); nneg_in = 1'b0; dneg_in = 1'b0;
               st_in  = frac_pkg::ST_DONE;
            end else begin
               st_in  = frac_pkg::ST_GCD;
            end
         end
         frac_pkg::ST_GCD: begin
            // Euclid: x, y <- y, x mod y until y is zero
            if (!dwait_ff) begin
               if (gy_ff == '0) begin
                  st_in    = frac_pkg::ST_DIVN;
                  dgo      = 1'b1;
                  ddvd     = num_ff;
                  ddvs     = gx_ff;
                  dwait_in = 1'b1;
               end else begin
                  dgo      = 1'b1;
                  dwait_in = 1'b1;
               end
            end else if (ddone) begin
               gx_in    = gy_ff;
               gy_in    = dr;
               dwait_in = 1'b0;
            end
         end
         frac_pkg::ST_DIVN: begin
            if (ddone) begin
               num_in = dq;
               dgo    = 1'b1;
               ddvd   = den_ff;
               ddvs   = gx_ff;
               st_in  = frac_pkg::ST_DIVD;
            end
         end
         frac_pkg::ST_DIVD: begin
            if (ddone) begin
               den_in   = dq;
               dwait_in = 1'b0;
               st_in    = frac_pkg::ST_DONE;
            end
         end
         frac_pkg::ST_DONE: begin
            vld_in = 1'b1;
            st_in  = frac_pkg::ST_IDLE;
         end
         default: st_in = frac_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= frac_pkg::ST_IDLE;
         step_ff  <= 2'd0;
         vld_ff   <= 1'b0;
         dwait_ff <= 1'b0;
      end else begin
         st_ff    <= st_in;
         step_ff  <= step_in;
         vld_ff   <= vld_in;
         dwait_ff <= dwait_in;
      end
      p0_ff <= p0_in; p1_ff <= p1_in; p2_ff <= p2_in;
      s0_ff <= s0_in; s1_ff <= s1_in; s2_ff <= s2_in;
      num_ff <= num_in; den_ff <= den_in; gx_ff <= gx_in; gy_ff <= gy_in;
      nneg_ff <= nneg_in; dneg_ff <= dneg_in;
      err_ff <= err_in;
   end

   // output register: driven on the cycle after DONE
   logic [frac_pkg::NUM_OUT_W-1:0] onum_ff;
   logic [frac_pkg::DEN_OUT_W-1:0] oden_ff;
   logic                           oerr_ff;
   logic [W:0]                     nmag_x, dmag_x, nbits, dbits;

   always_comb begin
      nmag_x = {1'b0, num_ff};
      dmag_x = {1'b0, den_ff};
      nbits  = nneg_ff ? ((W+1)'(0) - nmag_x) : nmag_x;
      dbits  = dneg_ff ? ((W+1)'(0) - dmag_x) : dmag_x;
   end

   always_ff @(posedge clock) begin
      if (st_ff == frac_pkg::ST_DONE) begin
         onum_ff <= frac_pkg::NUM_OUT_W'(nbits);
         oden_ff <= frac_pkg::DEN_OUT_W'(dbits);
         oerr_ff <= err_ff;
      end
   end

   assign busy             = (st_ff != frac_pkg::ST_IDLE);
   assign rsp_valid        = vld_ff;
   assign rsp_result_num   = onum_ff;
   assign rsp_result_den   = oden_ff;
   assign rsp_divide_error = oerr_ff;
endmodule

// ===== hdl/frac_divu.sv =====
// ----------------------------------------------------------------------------
// frac_divu: shared restoring divider
// Unsigned quotient, one bit per cycle; remainder available at done.
// ----------------------------------------------------------------------------
module frac_divu #(
   parameter int W = 34
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quot,
   output logic [W-1:0] rem
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [W:0]    trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      d_in    = d_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      trial   = {r_ff, q_ff[W-1]} - {1'b0, d_ff};
      if (go) begin
         q_in   = dividend;
         r_in   = '0;
         d_in   = divisor;
         cnt_in = CW'(W);
         run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[W]) begin
            r_in = trial[W-1:0];
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[W-2:0], q_ff[W-1]};
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;
endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: checks fraction_arith_reduce against an exact fraction predictor
// Sends directed and random operand sets for all four operations and compares
// each reduced numerator, denominator and error flag with the prediction.
// ----------------------------------------------------------------------------
module testbench;

   localparam int OW = frac_pkg::OPERAND_WIDTH_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_command = '0;
   logic signed [OW-1:0] req_a_num = '0, req_a_den = '0, req_b_num = '0, req_b_den = '0;
   logic rsp_valid;
   logic signed [frac_pkg::NUM_OUT_W-1:0] rsp_result_num;
   logic signed [frac_pkg::DEN_OUT_W-1:0] rsp_result_den;
   logic rsp_divide_error;

   typedef struct packed {
      logic [frac_pkg::NUM_OUT_W-1:0] num;
      logic [frac_pkg::DEN_OUT_W-1:0] den;
      logic                           err;
   } fraction_type;

   fraction_type reduced_q[$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int sender_idle_pct = 0;

   always #5 clock = ~clock;

   fraction_arith_reduce DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_a_num(req_a_num), .req_a_den(req_a_den),
      .req_b_num(req_b_num), .req_b_den(req_b_den),
      .rsp_valid(rsp_valid), .rsp_result_num(rsp_result_num),
      .rsp_result_den(rsp_result_den), .rsp_divide_error(rsp_divide_error)
   );

   function automatic longint unsigned gcd_of(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   // exact signed math in 64 bits; 16-bit operands can't overflow it
   function automatic fraction_type reduce_fraction(frac_pkg::cmd_type op,
         logic signed [OW-1:0] an, logic signed [OW-1:0] ad,
         logic signed [OW-1:0] bn, logic signed [OW-1:0] bd);
      longint n, d;
      longint unsigned nm, dm, g;
      fraction_type r;
      case (op)
         frac_pkg::CMD_ADD: begin
            n = longint'(an) * bd + longint'(ad) * bn;
            d = longint'(ad) * bd;
         end
         frac_pkg::CMD_SUB: begin
            n = longint'(an) * bd - longint'(ad) * bn;
            d = longint'(ad) * bd;
         end
         frac_pkg::CMD_MUL: begin
            n = longint'(an) * bn;
            d = longint'(ad) * bd;
         end
         default: begin
            n = longint'(an) * bd;
            d = longint'(ad) * bn;
         end
      endcase
      r = '{num: '0, den: 1, err: 1'b0};
      if (d == 0) r.err = 1'b1;
      else if (n != 0) begin
         nm = (n < 0) ? -n : n;
         dm = (d < 0) ? -d : d;
         g = gcd_of(nm, dm);
         n = n / longint'(g);    // signs stay where they fell
         d = d / longint'(g);
         r.num = n[frac_pkg::NUM_OUT_W-1:0];
         r.den = d[frac_pkg::DEN_OUT_W-1:0];
      end
      return r;
   endfunction

   // one item: optional sender gap, then hold start until busy drops
   task automatic send_item(frac_pkg::cmd_type op, logic [OW-1:0] an, logic [OW-1:0] ad,
         logic [OW-1:0] bn, logic [OW-1:0] bd);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      req_command <= op;
      req_a_num <= an; req_a_den <= ad; req_b_num <= bn; req_b_den <= bd;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      reduced_q = {reduced_q, reduce_fraction(op, an, ad, bn, bd)};
      items_sent++;
      start <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (reduced_q.size() != 0) @(posedge clock);
   endtask

   // result checker: receiver can't stall, so take every strobe
   always @(posedge clock) begin
      fraction_type exp_r;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (reduced_q.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            exp_r = reduced_q.pop_front();
            if (rsp_result_num !== exp_r.num) begin
               $error("result_num exp %0d got %0d", $signed(exp_r.num), rsp_result_num);
               errors++;
            end
            if (rsp_result_den !== exp_r.den) begin
               $error("result_den exp %0d got %0d", $signed(exp_r.den), rsp_result_den);
               errors++;
            end
            if (rsp_divide_error !== exp_r.err) begin
               $error("divide_error exp %0b got %0b", exp_r.err, rsp_divide_error);
               errors++;
            end
         end
      end
   end

   function automatic logic [OW-1:0] rand_operand();
      case ($urandom_range(5))
         0: return OW'($urandom_range(8) - 4);   // tiny, zero, negatives
         1: return {1'b1, {(OW-1){1'b0}}};
         2: return {1'b0, {(OW-1){1'b1}}};
         3: return OW'($urandom_range(255) - 128);
         default: return OW'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic [OW-1:0] mn, mx;
      mn = {1'b1, {(OW-1){1'b0}}};
      mx = {1'b0, {(OW-1){1'b1}}};
      for (int op = 0; op < 4; op++) begin
         send_item(frac_pkg::cmd_type'(op), 3, 4, -5, 6);
         send_item(frac_pkg::cmd_type'(op), mn, mn, mn, mn);
         send_item(frac_pkg::cmd_type'(op), mx, mn, mn, mx);
      end
      send_item(frac_pkg::CMD_ADD, 1, 0, 1, 2);      // zero denominator
      send_item(frac_pkg::CMD_DIV, 1, 2, 0, 3);      // divide by zero fraction
      send_item(frac_pkg::CMD_MUL, 0, 0, 0, 0);      // both zero: error wins
      send_item(frac_pkg::CMD_SUB, 1, 2, 1, 2);      // difference is zero
      send_item(frac_pkg::CMD_MUL, 0, 7, 5, 3);      // zero numerator
      send_item(frac_pkg::CMD_ADD, mn, 1, mn, 1);    // sum reaches -2^16
      send_item(frac_pkg::CMD_MUL, mn, 1, mn, 1);    // product reaches 2^30
      send_item(frac_pkg::CMD_SUB, mn, -1, mx, 1);
      send_item(frac_pkg::CMD_ADD, -1, -1, -1, -1);  // negative over negative: signs cancel
      send_item(frac_pkg::CMD_DIV, 6, 4, -9, 12);
      send_item(frac_pkg::CMD_ADD, '1, '1, '1, '1);
   endtask

   task automatic test_random(int count, int idle_pct);
      sender_idle_pct = idle_pct;
      repeat (count)
         send_item(frac_pkg::cmd_type'($urandom_range(3)), rand_operand(), rand_operand(),
                   rand_operand(), rand_operand());
      sender_idle_pct = 0;
   endtask

   task automatic test_drain_pause();
      wait_drained();   // sender holds off until all results are in
      repeat (20)
         send_item(frac_pkg::cmd_type'($urandom_range(3)), OW'($urandom), OW'($urandom),
                   OW'($urandom), 1);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(400, 0);
      test_drain_pause();
      test_random(300, 80);
      test_random(250, 0);
      test_random(250, 16);
      wait_drained();
      repeat (400) @(posedge clock);
      $display("Sent %0d items over all four operations, checked %0d results.",
               items_sent, results_seen);
      if (errors == 0 && reduced_q.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #100ms;
      $display("Timeout with %0d results outstanding", reduced_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

// ===== sim.f =====
hdl/frac_pkg.sv
hdl/frac_divu.sv
hdl/fraction_arith_reduce.sv
sim/testbench.sv
